>>> hw/rtl/pip_pkg.sv
// Package: coordinate types, constants and the exact edge-crossing test.
package pip_pkg;

   localparam int COORD_BITS = 16;
   localparam int DIFF_BITS  = COORD_BITS + 1;
   localparam int PROD_BITS  = 2 * DIFF_BITS;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic [1:0]                   count_type;

   // Vertices needed for a real polygon; the vertex counter saturates here.
   localparam count_type MIN_VERTICES = 2'd3;

   // Command codes of an input word.
   typedef enum logic {
      CMD_START  = 1'b0,
      CMD_VERTEX = 1'b1
   } cmd_type;

   // Edge old->new toggles parity when it straddles tx (half-open) and the
   // test point lies below it. Compare is exact via cross multiplication.
   function automatic logic edge_crosses(input coord_type ox, input coord_type oy,
                                         input coord_type nx, input coord_type ny,
                                         input coord_type tx, input coord_type ty);
      coord_type lx, ly, rx, ry;
      prod_type  lhs, rhs;
      logic      straddle;
      if (nx > ox) begin
         lx = ox; ly = oy; rx = nx; ry = ny;
      end else begin
         lx = nx; ly = ny; rx = ox; ry = oy;
      end
      straddle = ((nx < tx) == (tx <= ox));
      lhs = prod_type'(diff_type'(ty) - diff_type'(ly))
          * prod_type'(diff_type'(rx) - diff_type'(lx));
      rhs = prod_type'(diff_type'(ry) - diff_type'(ly))
          * prod_type'(diff_type'(tx) - diff_type'(lx));
      return straddle && (lhs < rhs);
   endfunction

endpackage

>>> hw/rtl/pip_chan_if.sv
// Interfaces: request and response channels with valid/ready handshake.
interface pip_req_if;
   logic               valid;
   logic               ready;
   pip_pkg::cmd_type   cmd;
   pip_pkg::coord_type x_coord;
   pip_pkg::coord_type y_coord;
   logic               last_vertex;

   modport source (output valid, cmd, x_coord, y_coord, last_vertex, input ready);
   modport sink   (input valid, cmd, x_coord, y_coord, last_vertex, output ready);
endinterface

interface pip_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;
   logic too_few_vertices;

   modport source (output valid, inside_res, too_few_vertices, input ready);
   modport sink   (input valid, inside_res, too_few_vertices, output ready);
endinterface

>>> hw/rtl/point_in_polygon_test_core.sv
// Point-in-polygon even-odd crossing test core.
// Path: a closing vertex word goes through the input register, then the result
//   register; it waits in the input register while the result word is not taken.
// Throughput: one word per cycle unless stalled; both edge tests run in parallel.
// Reset: synchronous; clears the test point, first/previous vertex, vertex count,
//   parity and both valid flags.
module point_in_polygon_test_core (
   input logic        clock,
   input logic        reset,
   pip_req_if.sink    req_chan,
   pip_rsp_if.source  rsp_chan
);

   // Input register
   logic                s1_valid_ff;
   pip_pkg::cmd_type    s1_cmd_ff;
   pip_pkg::coord_type  s1_x_ff, s1_y_ff;
   logic                s1_last_ff;

   // Query state
   pip_pkg::coord_type  test_x_ff, test_y_ff, first_x_ff, first_y_ff;
   pip_pkg::coord_type  prev_x_ff, prev_y_ff;
   pip_pkg::count_type  count_ff, count_in;
   logic                parity_ff, parity_in;

   // Result register
   logic                rsp_valid_ff;
   logic                inside_ff, inside_in;
   logic                too_few_ff, too_few_in;

   logic                is_vertex, makes_result, s1_adv, req_take;
   logic                edge_new, edge_close;
   pip_pkg::count_type  count_inc;

   // Decide whether the registered word can move on
   assign is_vertex    = (s1_cmd_ff == pip_pkg::CMD_VERTEX);
   assign makes_result = is_vertex && s1_last_ff;
   assign s1_adv       = s1_valid_ff && (!makes_result || !rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_take     = req_chan.valid && req_chan.ready;

   // Edge tests: previous->new and closing new->first
   assign edge_new   = pip_pkg::edge_crosses(prev_x_ff, prev_y_ff, s1_x_ff, s1_y_ff,
                                             test_x_ff, test_y_ff);
   assign edge_close = pip_pkg::edge_crosses(s1_x_ff, s1_y_ff, first_x_ff, first_y_ff,
                                             test_x_ff, test_y_ff);

   // Next count, parity and result fields
   always_comb begin
      count_inc = (count_ff < pip_pkg::MIN_VERTICES) ? count_ff + 2'd1 : count_ff;
      parity_in = parity_ff ^ ((count_ff != 2'd0) && edge_new);
      count_in  = count_inc;
      inside_in  = 1'b0;
      too_few_in = 1'b0;
      if (s1_last_ff) begin
         if (count_inc < pip_pkg::MIN_VERTICES) begin
            too_few_in = 1'b1;
         end else begin
            inside_in = parity_in ^ edge_close;
         end
         count_in  = 2'd0;
         parity_in = 1'b0;
      end
   end

   // Load the input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
      if (req_take) begin
         s1_cmd_ff  <= req_chan.cmd;
         s1_x_ff    <= req_chan.x_coord;
         s1_y_ff    <= req_chan.y_coord;
         s1_last_ff <= req_chan.last_vertex;
      end
   end

   // Advance the query state
   always_ff @(posedge clock) begin
      if (reset) begin
         test_x_ff  <= '0;
         test_y_ff  <= '0;
         first_x_ff <= '0;
         first_y_ff <= '0;
         prev_x_ff  <= '0;
         prev_y_ff  <= '0;
         count_ff   <= '0;
         parity_ff  <= 1'b0;
      end else if (s1_adv) begin
         if (!is_vertex) begin
            test_x_ff <= s1_x_ff;
            test_y_ff <= s1_y_ff;
            count_ff  <= '0;
            parity_ff <= 1'b0;
         end else begin
            if (count_ff == 2'd0) begin
               first_x_ff <= s1_x_ff;
               first_y_ff <= s1_y_ff;
            end
            prev_x_ff <= s1_x_ff;
            prev_y_ff <= s1_y_ff;
            count_ff  <= count_in;
            parity_ff <= parity_in;
         end
      end
   end

   // Hold or replace the result word
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv && makes_result) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (s1_adv && makes_result) begin
         inside_ff  <= inside_in;
         too_few_ff <= too_few_in;
      end
   end

   assign rsp_chan.valid            = rsp_valid_ff;
   assign rsp_chan.inside_res       = inside_ff;
   assign rsp_chan.too_few_vertices = too_few_ff;

   // Checks
   a_take_loads: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted word did not reach the input register");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && makes_result) |=> (count_ff == 2'd0) && !parity_ff && rsp_valid_ff)
      else $error("closing vertex did not clear the query state");

   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(inside_ff && too_few_ff))
      else $error("inside and too-few flags both set");

endmodule

>>> sim/tb_top.sv
// Testbench for the point-in-polygon crossing core: random polygons, predicted verdicts.
module tb_top;

   localparam pip_pkg::coord_type C_MIN = 16'sh8000;
   localparam pip_pkg::coord_type C_MAX = 16'sh7fff;

   typedef struct packed {
      logic enclosed;
      logic few;
   } verdict_type;

   // Track the polygon walk word by word and queue the verdict of each closing vertex.
   class crossing_scoreboard;
      pip_pkg::coord_type  pt_x, pt_y, first_x, first_y, prev_x, prev_y;
      pip_pkg::count_type  seen;
      bit                  flip;
      verdict_type         pending_verdicts[$];
      int                  words_taken;
      int                  errors;

      function new();
         pt_x = '0; pt_y = '0; first_x = '0; first_y = '0; prev_x = '0; prev_y = '0;
         seen = '0; flip = 1'b0; words_taken = 0; errors = 0;
      endfunction

      // Decide whether edge from (ax,ay) to (bx,by) flips the even-odd parity.
      function bit flips_parity(pip_pkg::coord_type ax, pip_pkg::coord_type ay,
                                pip_pkg::coord_type bx, pip_pkg::coord_type by);
         longint o_x, o_y, n_x, n_y, l_x, l_y, r_x, r_y, t_x, t_y;
         o_x = ax; o_y = ay; n_x = bx; n_y = by; t_x = pt_x; t_y = pt_y;
         if (n_x > o_x) begin
            l_x = o_x; l_y = o_y; r_x = n_x; r_y = n_y;
         end else begin
            l_x = n_x; l_y = n_y; r_x = o_x; r_y = o_y;
         end
         // half-open straddle of the test x
         if ((n_x < t_x) != (t_x <= o_x))
            return 1'b0;
         return ((t_y - l_y) * (r_x - l_x)) < ((r_y - l_y) * (t_x - l_x));
      endfunction

      function void take_word(pip_pkg::cmd_type cmd, pip_pkg::coord_type x,
                              pip_pkg::coord_type y, logic last);
         verdict_type v;
         words_taken++;
         if (cmd == pip_pkg::CMD_START) begin
            pt_x = x; pt_y = y; seen = '0; flip = 1'b0;
            return;
         end
         if (seen == 2'd0) begin
            first_x = x; first_y = y;
         end else begin
            flip ^= flips_parity(prev_x, prev_y, x, y);
         end
         prev_x = x; prev_y = y;
         if (seen < pip_pkg::MIN_VERTICES)
            seen++;
         if (!last)
            return;
         // close the polygon back to its first vertex
         if (seen < pip_pkg::MIN_VERTICES) begin
            v.enclosed = 1'b0; v.few = 1'b1;
         end else begin
            flip ^= flips_parity(x, y, first_x, first_y);
            v.enclosed = flip; v.few = 1'b0;
         end
         pending_verdicts.push_back(v);
         seen = '0; flip = 1'b0;
      endfunction

      function void check_verdict(logic enclosed, logic few);
         verdict_type exp_v;
         if (pending_verdicts.size() == 0) begin
            $display("%0t: unexpected result word inside_res=%b too_few_vertices=%b",
                     $time, enclosed, few);
            errors++;
            return;
         end
         exp_v = pending_verdicts.pop_front();
         if (enclosed !== exp_v.enclosed) begin
            $display("%0t: inside_res mismatch expected %b actual %b",
                     $time, exp_v.enclosed, enclosed);
            errors++;
         end
         if (few !== exp_v.few) begin
            $display("%0t: too_few_vertices mismatch expected %b actual %b",
                     $time, exp_v.few, few);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   quiet = 1'b0;
   bit   held_off = 1'b0;
   int   words_sent = 0;
   crossing_scoreboard sb;

   pip_req_if req_if ();
   pip_rsp_if rsp_if ();

   point_in_polygon_test_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if)
   );

   always #4 clock = ~clock;

   // Offer one word, idling first at random; return once it is accepted.
   task automatic send_word(pip_pkg::cmd_type cmd, pip_pkg::coord_type x,
                            pip_pkg::coord_type y, logic last);
      bit fire;
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(posedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.cmd         <= cmd;
      req_if.x_coord     <= x;
      req_if.y_coord     <= y;
      req_if.last_vertex <= last;
      do begin
         @(negedge clock);
         fire = req_if.ready;
         @(posedge clock);
      end while (!fire);
      sb.take_word(cmd, x, y, last);
      words_sent++;
      if (words_sent >= 1000)
         quiet = 1'b1;
   endtask

   // Pick a coordinate near a center: tight, moderate, anywhere, or an extreme.
   function automatic pip_pkg::coord_type pick_coord(pip_pkg::coord_type center, int mode);
      int v;
      case (mode)
         0: v = int'(center) + int'($urandom_range(0, 40)) - 20;
         1: v = int'(center) + int'($urandom_range(0, 4000)) - 2000;
         2: v = int'($urandom);
         default: begin
            case ($urandom_range(0, 6))
               0: v = -32768;
               1: v = -32767;
               2: v = -1;
               3: v = 0;
               4: v = 1;
               5: v = 32766;
               default: v = 32767;
            endcase
         end
      endcase
      return pip_pkg::coord_type'(v);
   endfunction

   task automatic run_directed();
      // vertex words before any start use the reset point (0,0)
      send_word(pip_pkg::CMD_VERTEX, -16'sd10, -16'sd10, 1'b0);
      send_word(pip_pkg::CMD_VERTEX, 16'sd10, -16'sd10, 1'b0);
      send_word(pip_pkg::CMD_VERTEX, 16'sd0, 16'sd10, 1'b1);
      // last flag on a start word is ignored
      send_word(pip_pkg::CMD_START, 16'sd3, 16'sd2, 1'b1);
      // one- and two-vertex polygons report too few
      send_word(pip_pkg::CMD_VERTEX, 16'sd5, 16'sd5, 1'b1);
      send_word(pip_pkg::CMD_VERTEX, 16'sd0, 16'sd0, 1'b0);
      send_word(pip_pkg::CMD_VERTEX, 16'sd9, 16'sd9, 1'b1);
      // full-range square around the origin
      send_word(pip_pkg::CMD_START, 16'sd0, 16'sd0, 1'b0);
      send_word(pip_pkg::CMD_VERTEX, C_MIN, C_MIN, 1'b0);
      send_word(pip_pkg::CMD_VERTEX, C_MAX, C_MIN, 1'b0);
      send_word(pip_pkg::CMD_VERTEX, C_MAX, C_MAX, 1'b0);
      send_word(pip_pkg::CMD_VERTEX, C_MIN, C_MAX, 1'b1);
      // second polygon against the kept test point
      send_word(pip_pkg::CMD_VERTEX, 16'sd100, 16'sd100, 1'b0);
      send_word(pip_pkg::CMD_VERTEX, 16'sd200, 16'sd100, 1'b0);
      send_word(pip_pkg::CMD_VERTEX, 16'sd150, 16'sd200, 1'b1);
      // test point on a corner of the full-range square
      send_word(pip_pkg::CMD_START, C_MAX, C_MIN, 1'b0);
      send_word(pip_pkg::CMD_VERTEX, C_MIN, C_MAX, 1'b0);
      send_word(pip_pkg::CMD_VERTEX, C_MAX, C_MAX, 1'b0);
      send_word(pip_pkg::CMD_VERTEX, C_MAX, C_MIN, 1'b0);
      send_word(pip_pkg::CMD_VERTEX, C_MIN, C_MIN, 1'b1);
      // vertical edge at the extreme x, point at its top end
      send_word(pip_pkg::CMD_START, C_MIN, C_MAX, 1'b0);
      send_word(pip_pkg::CMD_VERTEX, C_MIN, C_MIN, 1'b0);
      send_word(pip_pkg::CMD_VERTEX, C_MIN, C_MAX, 1'b0);
      send_word(pip_pkg::CMD_VERTEX, 16'sd0, 16'sd0, 1'b1);
   endtask

   // Mostly whole polygons with random content, some noise and cut-off walks.
   task automatic run_random();
      pip_pkg::coord_type tp_x, tp_y;
      int                 mode, nverts, r;
      bit                 cut;
      tp_x = '0; tp_y = '0;
      while (words_sent < 1100) begin
         if ($urandom_range(0, 99) < 8) begin
            send_word(pip_pkg::cmd_type'($urandom_range(0, 1)),
                      pip_pkg::coord_type'($urandom),
                      pip_pkg::coord_type'($urandom), $urandom_range(0, 2) == 0);
         end else begin
            r = $urandom_range(0, 9);
            mode = (r < 4) ? 0 : (r < 7) ? 1 : (r < 9) ? 2 : 3;
            if ($urandom_range(0, 9) != 0) begin
               tp_x = ($urandom_range(0, 3) == 0) ? pick_coord('0, 3)
                                                  : pip_pkg::coord_type'($urandom);
               tp_y = ($urandom_range(0, 3) == 0) ? pick_coord('0, 3)
                                                  : pip_pkg::coord_type'($urandom);
               send_word(pip_pkg::CMD_START, tp_x, tp_y, 1'($urandom_range(0, 1)));
            end
            r = $urandom_range(0, 19);
            nverts = (r < 2) ? $urandom_range(1, 2) :
                     (r < 4) ? $urandom_range(9, 24) : $urandom_range(3, 8);
            cut = ($urandom_range(0, 14) == 0);
            for (int i = 0; i < nverts; i++)
               send_word(pip_pkg::CMD_VERTEX, pick_coord(tp_x, mode),
                         pick_coord(tp_y, mode), (i == nverts - 1) && !cut);
         end
      end
   endtask

   // Main sequence: reset, directed words, random polygons, drain, verdict.
   initial begin
      sb = new();
      req_if.valid       <= 1'b0;
      req_if.cmd         <= pip_pkg::CMD_START;
      req_if.x_coord     <= '0;
      req_if.y_coord     <= '0;
      req_if.last_vertex <= 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      run_directed();
      run_random();
      req_if.valid <= 1'b0;
      while (sb.pending_verdicts.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.errors == 0) begin
         $display("point_in_polygon_test_core verification clean");
      end else begin
         $display("point_in_polygon_test_core verification failed");
      end
      $finish;
   end

   // Drive result ready: random stalls, one long hold-off, steady at the end.
   initial begin
      rsp_if.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && !quiet && sb.words_taken >= 300) begin
            held_off = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (500) @(posedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(posedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   // Check each result word ahead of the edge that accepts it.
   always @(negedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_verdict(rsp_if.inside_res, rsp_if.too_few_vertices);
   end

   // Stop a hung run.
   initial begin
      #2000000;
      $display("point_in_polygon_test_core verification failed");
      $finish;
   end

endmodule
